// ----- sv/dlcd_pkg.sv -----
// ----------------------------------------------------------------------------
// dlcd_pkg
// Shared types, constants and bit-serial helpers for the debounced level
// change detector.
// ----------------------------------------------------------------------------
package dlcd_pkg;

  localparam int LEVEL_W = 12;
  localparam int TIME_W  = 32;
  localparam int SPAN_W  = 16;
  localparam int CFG_W   = 16;
  localparam int INDEX_W = 2;
  localparam int QUOT_W  = 12;
  localparam int BIT_W   = $clog2(TIME_W);

  localparam int MAX_CAND_COUNT_DEF = 4096;

  localparam logic [INDEX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [INDEX_W-1:0] REG_DEBOUNCE  = 2'd1;
  localparam logic [INDEX_W-1:0] REG_HEARTBEAT = 2'd2;

  localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 12'd100;
  localparam logic [SPAN_W-1:0]  DEBOUNCE_RST  = 16'd50;
  localparam logic [SPAN_W-1:0]  HEARTBEAT_RST = 16'd5000;

  typedef enum logic [1:0] {
    KIND_INIT   = 2'd0,
    KIND_CHANGE = 2'd1,
    KIND_BEAT   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS,
    ST_DECIDE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic near_stable;
    logic far_cand;
    logic debounce_ok;
    logic beat_ok;
  } pass_flags_t;

  typedef struct packed {
    kind_t              kind;
    logic [TIME_W-1:0]  stamp;
    logic [LEVEL_W-1:0] prev_level;
    logic [LEVEL_W-1:0] level;
    logic [TIME_W-1:0]  held;
    logic               last;
  } result_t;

  function automatic logic fa_sum(input logic x, input logic y, input logic c);
    return x ^ y ^ c;
  endfunction

  function automatic logic fa_carry(input logic x, input logic y, input logic c);
    return (x & y) | (x & c) | (y & c);
  endfunction

  function automatic logic sub_borrow(input logic x, input logic y, input logic b);
    return (~x & y) | (~(x ^ y) & b);
  endfunction

  // LSB-first magnitude compare: a differing higher bit decides
  function automatic logic ge_next(input logic ge, input logic x, input logic y);
    return (x != y) ? x : ge;
  endfunction

endpackage

// ----- sv/dlcd_serial_pass.sv -----
// ----------------------------------------------------------------------------
// dlcd_serial_pass
// Bit-serial pass over one item: level distance checks, elapsed times,
// held time and candidate sum update, one bit per cycle while step is high, LSB first.
// ----------------------------------------------------------------------------
module dlcd_serial_pass #(
  parameter int SUM_W = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  load,
  input  logic                                  step,
  input  logic [dlcd_pkg::LEVEL_W-1:0]          sample_mv,
  input  logic [dlcd_pkg::LEVEL_W-1:0]          stable_level,
  input  logic [dlcd_pkg::LEVEL_W-1:0]          cand_level,
  input  logic [dlcd_pkg::LEVEL_W-1:0]          threshold_mv,
  input  logic [dlcd_pkg::TIME_W-1:0]           time_ms,
  input  logic [dlcd_pkg::TIME_W-1:0]           stable_since,
  input  logic [dlcd_pkg::TIME_W-1:0]           cand_since,
  input  logic [dlcd_pkg::TIME_W-1:0]           last_beat,
  input  logic [dlcd_pkg::SPAN_W-1:0]           debounce_ms,
  input  logic [dlcd_pkg::SPAN_W-1:0]           heartbeat_ms,
  input  logic [SUM_W-1:0]                      cand_sum,
  output logic                                  pass_done,
  output dlcd_pkg::pass_flags_t                 flags,
  output logic [dlcd_pkg::TIME_W-1:0]           held_ms,
  output logic [SUM_W-1:0]                      sum_plus
);

  localparam logic [dlcd_pkg::BIT_W:0] SUM_BITS = (dlcd_pkg::BIT_W + 1)'(SUM_W);

  logic [dlcd_pkg::BIT_W-1:0]   cnt;
  logic [dlcd_pkg::LEVEL_W-1:0] a_sr, s_sr, c_sr, t_sr;
  logic [dlcd_pkg::TIME_W-1:0]  n_sr, ss_sr, cs_sr, lb_sr;
  logic [dlcd_pkg::SPAN_W-1:0]  d_sr, h_sr;
  logic [SUM_W-1:0]             sum_sr;
  logic                         cy_st, cy_at, cy_ct, cy_sum;
  logic                         bw_h, bw_c, bw_b;
  logic                         ge_st_a, ge_at_s, ge_ct_a, ge_at_c, ge_dc, ge_db;

  logic a, s, c, t, n;
  logic st, at, ct, dh, dc, db, sb;

  always_comb begin
    a  = a_sr[0];
    s  = s_sr[0];
    c  = c_sr[0];
    t  = t_sr[0];
    n  = n_sr[0];
    st = dlcd_pkg::fa_sum(s, t, cy_st);
    at = dlcd_pkg::fa_sum(a, t, cy_at);
    ct = dlcd_pkg::fa_sum(c, t, cy_ct);
    dh = dlcd_pkg::fa_sum(n, ss_sr[0], bw_h);
    dc = dlcd_pkg::fa_sum(n, cs_sr[0], bw_c);
    db = dlcd_pkg::fa_sum(n, lb_sr[0], bw_b);
    sb = dlcd_pkg::fa_sum(sum_sr[0], a, cy_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_sr    <= sample_mv;
      s_sr    <= stable_level;
      c_sr    <= cand_level;
      t_sr    <= threshold_mv;
      n_sr    <= time_ms;
      ss_sr   <= stable_since;
      cs_sr   <= cand_since;
      lb_sr   <= last_beat;
      d_sr    <= debounce_ms;
      h_sr    <= heartbeat_ms;
      sum_sr  <= cand_sum;
      cy_st   <= 1'b0;
      cy_at   <= 1'b0;
      cy_ct   <= 1'b0;
      cy_sum  <= 1'b0;
      bw_h    <= 1'b0;
      bw_c    <= 1'b0;
      bw_b    <= 1'b0;
      ge_st_a <= 1'b1;
      ge_at_s <= 1'b1;
      ge_ct_a <= 1'b1;
      ge_at_c <= 1'b1;
      ge_dc   <= 1'b1;
      ge_db   <= 1'b1;
    end else if (step) begin
      a_sr    <= {1'b0, a_sr[dlcd_pkg::LEVEL_W-1:1]};
      s_sr    <= {1'b0, s_sr[dlcd_pkg::LEVEL_W-1:1]};
      c_sr    <= {1'b0, c_sr[dlcd_pkg::LEVEL_W-1:1]};
      t_sr    <= {1'b0, t_sr[dlcd_pkg::LEVEL_W-1:1]};
      n_sr    <= {1'b0, n_sr[dlcd_pkg::TIME_W-1:1]};
      ss_sr   <= {1'b0, ss_sr[dlcd_pkg::TIME_W-1:1]};
      cs_sr   <= {1'b0, cs_sr[dlcd_pkg::TIME_W-1:1]};
      lb_sr   <= {1'b0, lb_sr[dlcd_pkg::TIME_W-1:1]};
      d_sr    <= {1'b0, d_sr[dlcd_pkg::SPAN_W-1:1]};
      h_sr    <= {1'b0, h_sr[dlcd_pkg::SPAN_W-1:1]};
      sum_sr  <= {1'b0, sum_sr[SUM_W-1:1]};
      cy_st   <= dlcd_pkg::fa_carry(s, t, cy_st);
      cy_at   <= dlcd_pkg::fa_carry(a, t, cy_at);
      cy_ct   <= dlcd_pkg::fa_carry(c, t, cy_ct);
      cy_sum  <= dlcd_pkg::fa_carry(sum_sr[0], a, cy_sum);
      bw_h    <= dlcd_pkg::sub_borrow(n, ss_sr[0], bw_h);
      bw_c    <= dlcd_pkg::sub_borrow(n, cs_sr[0], bw_c);
      bw_b    <= dlcd_pkg::sub_borrow(n, lb_sr[0], bw_b);
      ge_st_a <= dlcd_pkg::ge_next(ge_st_a, st, a);
      ge_at_s <= dlcd_pkg::ge_next(ge_at_s, at, s);
      ge_ct_a <= dlcd_pkg::ge_next(ge_ct_a, ct, a);
      ge_at_c <= dlcd_pkg::ge_next(ge_at_c, at, c);
      ge_dc   <= dlcd_pkg::ge_next(ge_dc, dc, d_sr[0]);
      ge_db   <= dlcd_pkg::ge_next(ge_db, db, h_sr[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      held_ms <= {dh, held_ms[dlcd_pkg::TIME_W-1:1]};
      if ({1'b0, cnt} < SUM_BITS) begin
        sum_plus <= {sb, sum_plus[SUM_W-1:1]};
      end
    end
  end

  assign pass_done         = step && (cnt == dlcd_pkg::BIT_W'(dlcd_pkg::TIME_W - 1));
  assign flags.near_stable = ge_st_a & ge_at_s;
  assign flags.far_cand    = ~(ge_ct_a & ge_at_c);
  assign flags.debounce_ok = ge_dc;
  assign flags.beat_ok     = ge_db;

endmodule

// ----- sv/dlcd_div.sv -----
// ----------------------------------------------------------------------------
// dlcd_div
// Radix-2 restoring divider for the candidate average; one quotient bit
// per cycle, the quotient is known to fit in a level.
// ----------------------------------------------------------------------------
module dlcd_div #(
  parameter int SUM_W   = 24,
  parameter int COUNT_W = 13
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [SUM_W-1:0]             dividend,
  input  logic [COUNT_W-1:0]           divisor,
  output logic [dlcd_pkg::QUOT_W-1:0]  quotient,
  output logic                         done
);

  localparam int STEP_W = $clog2(dlcd_pkg::QUOT_W);

  logic [COUNT_W-1:0]          rem;
  logic [dlcd_pkg::QUOT_W-1:0] low;
  logic [STEP_W-1:0]           cnt;
  logic                        busy;
  logic [COUNT_W:0]            shifted;
  logic [COUNT_W:0]            trial;
  logic                        fits;

  always_comb begin
    shifted = {rem, low[dlcd_pkg::QUOT_W-1]};
    trial   = shifted - {1'b0, divisor};
    fits    = shifted >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(dlcd_pkg::QUOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= COUNT_W'(dividend[SUM_W-1:dlcd_pkg::QUOT_W]);
      low <= dividend[dlcd_pkg::QUOT_W-1:0];
    end else if (busy) begin
      rem      <= fits ? trial[COUNT_W-1:0] : shifted[COUNT_W-1:0];
      low      <= {low[dlcd_pkg::QUOT_W-2:0], 1'b0};
      quotient <= {quotient[dlcd_pkg::QUOT_W-2:0], fits};
    end
  end

endmodule

// ----- sv/debounced_level_change_detector.sv -----
// ----------------------------------------------------------------------------
// debounced_level_change_detector
// Tracks a debounced stable level from timestamped millivolt samples and
// reports the initial level, level changes and periodic heartbeats.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries sample_mv and time_ms. Output
//   channel out_valid/out_ready carries kind, stamp_ms, prev_level_mv,
//   level_mv, held_ms and last; one item yields zero, one or two results,
//   last marks the final one. Registers are written through cfg_wen,
//   cfg_index and cfg_data, by the user only while the block is idle; the
//   block does not enforce this. Index 3 is ignored. Timing: after an item
//   is taken, a bit-serial pass over the timestamps and levels runs, then
//   a decision state, then the serial divider when a level change fires,
//   then the commit, then idle with in_ready high. The first result is
//   offered in the cycle after commit.
//   Results sit in a two-entry output buffer. in_ready returns as soon as
//   the item is committed, even while results still wait; if the receiver
//   stalls, the next item waits at commit until the buffer has drained.
//   Reset (rst, synchronous) restores the register defaults and an unseeded
//   state; the next item seeds the level.
// ----------------------------------------------------------------------------
module debounced_level_change_detector #(
  parameter int MAX_CAND_COUNT = dlcd_pkg::MAX_CAND_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dlcd_pkg::LEVEL_W-1:0]   sample_mv,
  input  logic [dlcd_pkg::TIME_W-1:0]    time_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     kind,
  output logic [dlcd_pkg::TIME_W-1:0]    stamp_ms,
  output logic [dlcd_pkg::LEVEL_W-1:0]   prev_level_mv,
  output logic [dlcd_pkg::LEVEL_W-1:0]   level_mv,
  output logic [dlcd_pkg::TIME_W-1:0]    held_ms,
  output logic                           last,
  input  logic                           cfg_wen,
  input  logic [dlcd_pkg::INDEX_W-1:0]   cfg_index,
  input  logic [dlcd_pkg::CFG_W-1:0]     cfg_data
);

  localparam int COUNT_W = $clog2(MAX_CAND_COUNT + 1);
  localparam int SUM_W   = dlcd_pkg::LEVEL_W + $clog2(MAX_CAND_COUNT);

  logic [dlcd_pkg::LEVEL_W-1:0] threshold;
  logic [dlcd_pkg::SPAN_W-1:0]  debounce;
  logic [dlcd_pkg::SPAN_W-1:0]  heartbeat;

  logic                         seeded;
  logic [dlcd_pkg::LEVEL_W-1:0] stable_level;
  logic [dlcd_pkg::TIME_W-1:0]  stable_since;
  logic                         cand_valid;
  logic [dlcd_pkg::LEVEL_W-1:0] cand_level;
  logic [dlcd_pkg::TIME_W-1:0]  cand_since;
  logic [SUM_W-1:0]             cand_sum;
  logic [COUNT_W-1:0]           cand_count;
  logic [dlcd_pkg::TIME_W-1:0]  last_beat;

  logic [dlcd_pkg::LEVEL_W-1:0] item_mv;
  logic [dlcd_pkg::TIME_W-1:0]  item_time;

  dlcd_pkg::state_t state, state_next;

  dlcd_pkg::result_t obuf [2];
  logic [1:0]        ocnt;

  logic                         in_take;
  logic                         out_take;
  logic                         pass_step;
  logic                         pass_done;
  dlcd_pkg::pass_flags_t        flags;
  logic [dlcd_pkg::TIME_W-1:0]  held_calc;
  logic [SUM_W-1:0]             sum_plus;
  logic                         div_start;
  logic                         div_done;
  logic [dlcd_pkg::QUOT_W-1:0]  quotient;

  logic                         count_full;
  logic [SUM_W-1:0]             sum_grow;
  logic [COUNT_W-1:0]           count_grow;
  logic                         restart;
  logic                         grow;
  logic                         fire;
  logic                         commit;
  logic [dlcd_pkg::LEVEL_W-1:0] level_new;
  dlcd_pkg::result_t            res_init, res_change, res_beat;

  assign in_ready  = (state == dlcd_pkg::ST_IDLE);
  assign in_take   = in_valid && in_ready;
  assign out_valid = (ocnt != 2'd0);
  assign out_take  = out_valid && out_ready;
  assign pass_step = (state == dlcd_pkg::ST_PASS);

  always_comb begin
    count_full = cand_count >= COUNT_W'(MAX_CAND_COUNT);
    sum_grow   = count_full ? cand_sum : sum_plus;
    count_grow = count_full ? cand_count : cand_count + COUNT_W'(1);
    restart    = !cand_valid || flags.far_cand;
    grow       = seeded && !flags.near_stable && !restart;
    fire       = grow && flags.debounce_ok;
    level_new  = fire ? quotient : stable_level;
  end

  dlcd_serial_pass #(
    .SUM_W(SUM_W)
  ) u_pass (
    .clk          (clk),
    .rst          (rst),
    .load         (in_take),
    .step         (pass_step),
    .sample_mv    (sample_mv),
    .stable_level (stable_level),
    .cand_level   (cand_level),
    .threshold_mv (threshold),
    .time_ms      (time_ms),
    .stable_since (stable_since),
    .cand_since   (cand_since),
    .last_beat    (last_beat),
    .debounce_ms  (debounce),
    .heartbeat_ms (heartbeat),
    .cand_sum     (cand_sum),
    .pass_done    (pass_done),
    .flags        (flags),
    .held_ms      (held_calc),
    .sum_plus     (sum_plus)
  );

  dlcd_div #(
    .SUM_W   (SUM_W),
    .COUNT_W (COUNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_grow),
    .divisor  (count_grow),
    .quotient (quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dlcd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    commit     = 1'b0;
    case (state)
      dlcd_pkg::ST_IDLE: begin
        if (in_take) state_next = dlcd_pkg::ST_PASS;
      end
      dlcd_pkg::ST_PASS: begin
        if (pass_done) state_next = dlcd_pkg::ST_DECIDE;
      end
      dlcd_pkg::ST_DECIDE: begin
        if (fire) begin
          div_start  = 1'b1;
          state_next = dlcd_pkg::ST_DIV;
        end else begin
          state_next = dlcd_pkg::ST_DONE;
        end
      end
      dlcd_pkg::ST_DIV: begin
        if (div_done) state_next = dlcd_pkg::ST_DONE;
      end
      dlcd_pkg::ST_DONE: begin
        if (ocnt == 2'd0) begin
          commit     = 1'b1;
          state_next = dlcd_pkg::ST_IDLE;
        end
      end
      default: state_next = dlcd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    res_init.kind       = dlcd_pkg::KIND_INIT;
    res_init.stamp      = item_time;
    res_init.prev_level = item_mv;
    res_init.level      = item_mv;
    res_init.held       = '0;
    res_init.last       = 1'b1;

    res_change.kind       = dlcd_pkg::KIND_CHANGE;
    res_change.stamp      = item_time;
    res_change.prev_level = stable_level;
    res_change.level      = quotient;
    res_change.held       = held_calc;
    res_change.last       = !flags.beat_ok;

    res_beat.kind       = dlcd_pkg::KIND_BEAT;
    res_beat.stamp      = item_time;
    res_beat.prev_level = level_new;
    res_beat.level      = level_new;
    res_beat.held       = '0;
    res_beat.last       = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_mv   <= sample_mv;
      item_time <= time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= dlcd_pkg::THRESHOLD_RST;
      debounce  <= dlcd_pkg::DEBOUNCE_RST;
      heartbeat <= dlcd_pkg::HEARTBEAT_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        dlcd_pkg::REG_THRESHOLD: threshold <= cfg_data[dlcd_pkg::LEVEL_W-1:0];
        dlcd_pkg::REG_DEBOUNCE:  debounce  <= cfg_data[dlcd_pkg::SPAN_W-1:0];
        dlcd_pkg::REG_HEARTBEAT: heartbeat <= cfg_data[dlcd_pkg::SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded       <= 1'b0;
      stable_level <= '0;
      stable_since <= '0;
      cand_valid   <= 1'b0;
      cand_level   <= '0;
      cand_since   <= '0;
      cand_sum     <= '0;
      cand_count   <= '0;
      last_beat    <= '0;
    end else if (commit) begin
      if (!seeded) begin
        seeded       <= 1'b1;
        stable_level <= item_mv;
        stable_since <= item_time;
      end else begin
        if (flags.near_stable || fire) begin
          cand_valid <= 1'b0;
          cand_level <= '0;
          cand_sum   <= '0;
          cand_count <= '0;
        end else if (restart) begin
          cand_valid <= 1'b1;
          cand_level <= item_mv;
          cand_since <= item_time;
          cand_sum   <= SUM_W'(item_mv);
          cand_count <= COUNT_W'(1);
        end else begin
          cand_sum   <= sum_grow;
          cand_count <= count_grow;
        end
        if (fire) begin
          stable_level <= quotient;
          stable_since <= item_time;
        end
        if (flags.beat_ok) begin
          last_beat <= item_time;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= 2'd0;
    end else if (commit) begin
      if (!seeded) begin
        ocnt <= 2'd1;
      end else begin
        ocnt <= {1'b0, fire} + {1'b0, flags.beat_ok};
      end
    end else if (out_take) begin
      ocnt <= ocnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (!seeded) begin
        obuf[0] <= res_init;
      end else if (fire) begin
        obuf[0] <= res_change;
        obuf[1] <= res_beat;
      end else begin
        obuf[0] <= res_beat;
      end
    end else if (out_take) begin
      obuf[0] <= obuf[1];
    end
  end

  assign kind          = obuf[0].kind;
  assign stamp_ms      = obuf[0].stamp;
  assign prev_level_mv = obuf[0].prev_level;
  assign level_mv      = obuf[0].level;
  assign held_ms       = obuf[0].held;
  assign last          = obuf[0].last;

`ifndef NO_ASSERTIONS
  a_ocnt_bound: assert property (@(posedge clk) disable iff (rst)
    ocnt != 2'd3)
    else $error("output buffer count out of range");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == dlcd_pkg::ST_DIV)
    else $error("divider finished outside the divide phase");

  a_commit_to_idle: assert property (@(posedge clk) disable iff (rst)
    commit |=> state == dlcd_pkg::ST_IDLE && (ocnt != 2'd0 || !$past(seeded)) == out_valid)
    else $error("commit did not return to idle");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state == dlcd_pkg::ST_PASS |=> !(state == dlcd_pkg::ST_IDLE && ocnt == 2'd0 && $past(commit)))
    else $error("pass did not run to completion");
`endif

endmodule

// ----- sim/tb_debounced_level_change_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_debounced_level_change_detector
// Self-checking bench: drives timestamped millivolt samples through the
// valid/ready input, predicts initial, change and heartbeat reports with an
// independent level tracker and compares every report field by field.
// ----------------------------------------------------------------------------
module tb_debounced_level_change_detector;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 64;
  localparam int CAND_LIMIT    = dlcd_pkg::MAX_CAND_COUNT_DEF;
  localparam int LONG_RUN      = 40;
  localparam logic [dlcd_pkg::INDEX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic [dlcd_pkg::LEVEL_W-1:0] mv;
    logic [dlcd_pkg::TIME_W-1:0]  stamp;
  } sample_t;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic [dlcd_pkg::LEVEL_W-1:0]  sample_mv = '0;
  logic [dlcd_pkg::TIME_W-1:0]   time_ms   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [1:0]                    kind;
  logic [dlcd_pkg::TIME_W-1:0]   stamp_ms;
  logic [dlcd_pkg::LEVEL_W-1:0]  prev_level_mv;
  logic [dlcd_pkg::LEVEL_W-1:0]  level_mv;
  logic [dlcd_pkg::TIME_W-1:0]   held_ms;
  logic                          last;
  logic                          cfg_wen   = 1'b0;
  logic [dlcd_pkg::INDEX_W-1:0]  cfg_index = '0;
  logic [dlcd_pkg::CFG_W-1:0]    cfg_data  = '0;

  sample_t           pending_samples[$];
  dlcd_pkg::result_t due_reports[$];
  logic              in_taken = 1'b0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold     = 0;
  int errors      = 0;
  int n_samples   = 0;
  int n_reports   = 0;
  int n_changes   = 0;
  int n_beats     = 0;
  int n_settings  = 0;

  logic [dlcd_pkg::LEVEL_W-1:0] cfg_threshold = dlcd_pkg::THRESHOLD_RST;
  logic [dlcd_pkg::SPAN_W-1:0]  cfg_debounce  = dlcd_pkg::DEBOUNCE_RST;
  logic [dlcd_pkg::SPAN_W-1:0]  cfg_heartbeat = dlcd_pkg::HEARTBEAT_RST;

  bit                           lv_seeded = 1'b0;
  logic [dlcd_pkg::LEVEL_W-1:0] lv_stable = '0;
  logic [dlcd_pkg::TIME_W-1:0]  lv_since  = '0;
  bit                           cd_valid  = 1'b0;
  logic [dlcd_pkg::LEVEL_W-1:0] cd_level  = '0;
  logic [dlcd_pkg::TIME_W-1:0]  cd_since  = '0;
  logic [23:0]                  cd_sum    = '0;
  logic [12:0]                  cd_count  = '0;
  logic [dlcd_pkg::TIME_W-1:0]  beat_at   = '0;

  logic [dlcd_pkg::TIME_W-1:0]  gen_time   = '0;
  int                           gen_target = 2048;

  debounced_level_change_detector #(
    .MAX_CAND_COUNT(CAND_LIMIT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample_mv(sample_mv),
    .time_ms(time_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .stamp_ms(stamp_ms),
    .prev_level_mv(prev_level_mv),
    .level_mv(level_mv),
    .held_ms(held_ms),
    .last(last),
    .cfg_wen(cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int unsigned mv_dist(logic [dlcd_pkg::LEVEL_W-1:0] a,
                                          logic [dlcd_pkg::LEVEL_W-1:0] b);
    return (a >= b) ? int'(a - b) : int'(b - a);
  endfunction

  function automatic dlcd_pkg::result_t make_report(dlcd_pkg::kind_t k,
                                                    logic [dlcd_pkg::TIME_W-1:0] stamp,
                                                    logic [dlcd_pkg::LEVEL_W-1:0] prev,
                                                    logic [dlcd_pkg::LEVEL_W-1:0] lvl,
                                                    logic [dlcd_pkg::TIME_W-1:0] held);
    dlcd_pkg::result_t r;
    r.kind       = k;
    r.stamp      = stamp;
    r.prev_level = prev;
    r.level      = lvl;
    r.held       = held;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic void track_level(logic [dlcd_pkg::LEVEL_W-1:0] mv,
                                      logic [dlcd_pkg::TIME_W-1:0] now);
    dlcd_pkg::result_t            found[$];
    logic [dlcd_pkg::LEVEL_W-1:0] avg;
    if (!lv_seeded) begin
      lv_seeded = 1'b1;
      lv_stable = mv;
      lv_since  = now;
      found.push_back(make_report(dlcd_pkg::KIND_INIT, now, mv, mv, '0));
    end else begin
      if (mv_dist(mv, lv_stable) <= cfg_threshold) begin
        cd_valid = 1'b0;
        cd_level = '0;
        cd_sum   = '0;
        cd_count = '0;
      end else if (!cd_valid || mv_dist(mv, cd_level) > cfg_threshold) begin
        cd_valid = 1'b1;
        cd_level = mv;
        cd_since = now;
        cd_sum   = 24'(mv);
        cd_count = 13'd1;
      end else begin
        if (cd_count < CAND_LIMIT) begin
          cd_sum   = cd_sum + 24'(mv);
          cd_count = cd_count + 13'd1;
        end
        if (dlcd_pkg::TIME_W'(now - cd_since) >= cfg_debounce) begin
          avg = dlcd_pkg::LEVEL_W'(cd_sum / cd_count);
          found.push_back(make_report(dlcd_pkg::KIND_CHANGE, now, lv_stable, avg,
                                      now - lv_since));
          lv_stable = avg;
          lv_since  = now;
          cd_valid  = 1'b0;
          cd_level  = '0;
          cd_sum    = '0;
          cd_count  = '0;
        end
      end
      if (dlcd_pkg::TIME_W'(now - beat_at) >= cfg_heartbeat) begin
        beat_at = now;
        found.push_back(make_report(dlcd_pkg::KIND_BEAT, now, lv_stable, lv_stable, '0));
      end
    end
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[i]) due_reports.push_back(found[i]);
  endfunction

  function automatic logic [dlcd_pkg::LEVEL_W-1:0] clamp_mv(int v);
    if (v < 0) return '0;
    if (v > 4095) return 12'd4095;
    return dlcd_pkg::LEVEL_W'(v);
  endfunction

  // feed samples; hold each until taken
  always @(negedge clk) begin : feed
    sample_t itm;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_samples.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
        itm = pending_samples.pop_front();
        sample_mv <= itm.mv;
        time_ms   <= itm.stamp;
        in_valid  <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rx_hold > 0) rx_hold <= rx_hold - 1;
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (rx_hold == 0) && ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : watch
    dlcd_pkg::result_t want;
    if (!rst) begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        track_level(sample_mv, time_ms);
        n_samples++;
      end
      if (out_valid && out_ready) begin
        if (due_reports.size() == 0) begin
          report_error($sformatf("report kind %0d level %0d with none pending",
                                 kind, level_mv));
        end else begin
          want = due_reports.pop_front();
          n_reports++;
          if (want.kind == dlcd_pkg::KIND_CHANGE) n_changes++;
          if (want.kind == dlcd_pkg::KIND_BEAT) n_beats++;
          if (kind !== want.kind)
            report_error($sformatf("kind: got %0d, want %0d", kind, want.kind));
          if (stamp_ms !== want.stamp)
            report_error($sformatf("stamp_ms: got %0h, want %0h", stamp_ms, want.stamp));
          if (prev_level_mv !== want.prev_level)
            report_error($sformatf("prev_level_mv: got %0d, want %0d",
                                   prev_level_mv, want.prev_level));
          if (level_mv !== want.level)
            report_error($sformatf("level_mv: got %0d, want %0d", level_mv, want.level));
          if (held_ms !== want.held)
            report_error($sformatf("held_ms: got %0h, want %0h", held_ms, want.held));
          if (last !== want.last)
            report_error($sformatf("last: got %0b, want %0b", last, want.last));
        end
      end
    end
  end

  task automatic add_sample(logic [dlcd_pkg::LEVEL_W-1:0] mv,
                            logic [dlcd_pkg::TIME_W-1:0] dt);
    gen_time = gen_time + dt;
    pending_samples.push_back('{mv, gen_time});
  endtask

  task automatic settle();
    do @(posedge clk);
    while (pending_samples.size() != 0 || in_valid || due_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [dlcd_pkg::INDEX_W-1:0] idx,
                           logic [dlcd_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      dlcd_pkg::REG_THRESHOLD: cfg_threshold = data[dlcd_pkg::LEVEL_W-1:0];
      dlcd_pkg::REG_DEBOUNCE:  cfg_debounce  = data[dlcd_pkg::SPAN_W-1:0];
      dlcd_pkg::REG_HEARTBEAT: cfg_heartbeat = data[dlcd_pkg::SPAN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [dlcd_pkg::CFG_W-1:0] thr, logic [dlcd_pkg::CFG_W-1:0] deb,
                           logic [dlcd_pkg::CFG_W-1:0] hb);
    settle();
    write_reg(dlcd_pkg::REG_THRESHOLD, thr);
    write_reg(dlcd_pkg::REG_DEBOUNCE, deb);
    write_reg(dlcd_pkg::REG_HEARTBEAT, hb);
    @(negedge clk) cfg_wen <= 1'b0;
    n_settings++;
  endtask

  task automatic set_pace(int tx, int rx);
    @(posedge clk);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
  endtask

  task automatic add_random(int n);
    int added, roll, len, spread, step_max, jump;
    added = 0;
    while (added < n) begin
      roll     = $urandom_range(99, 0);
      spread   = int'(cfg_threshold) / 3;
      step_max = int'(cfg_debounce) / 3 + 1;
      if (roll < 80) begin
        if ($urandom_range(1, 0)) begin
          gen_target = $urandom_range(4095, 0);
        end else begin
          jump = int'(cfg_threshold) + 1 + int'($urandom_range(2 * int'(cfg_threshold), 0));
          gen_target = $urandom_range(1, 0) ? gen_target + jump : gen_target - jump;
          gen_target = int'(clamp_mv(gen_target));
        end
        len = $urandom_range(12, 1);
        for (int k = 0; k < len && added < n; k++) begin
          add_sample(clamp_mv(gen_target + int'($urandom_range(2 * spread, 0)) - spread),
                     $urandom_range(step_max, 0));
          added++;
        end
      end else if (roll < 95) begin
        add_sample(dlcd_pkg::LEVEL_W'($urandom_range(4095, 0)),
                   $urandom_range(int'(cfg_heartbeat) + 100, 0));
        added++;
      end else begin
        gen_time = $urandom();
        add_sample(dlcd_pkg::LEVEL_W'($urandom_range(4095, 0)), 0);
        added++;
      end
    end
  endtask

  // park a candidate near full scale with a frozen clock for a long run
  task automatic fill_candidate();
    add_sample(12'd500, 1000);
    add_sample(12'd500, 10);
    add_sample(12'd500, 10);
    add_sample(12'd4095, 10);
    repeat (LONG_RUN) add_sample(dlcd_pkg::LEVEL_W'(3900 + $urandom_range(195, 0)), 0);
    add_sample(12'd4095, 1);
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    set_pace(7, 73);

    gen_time = 32'hFFFF_FFC0;
    add_sample(12'd2000, 0);
    add_sample(12'd2050, 10);
    add_sample(12'd3000, 10);
    add_sample(12'd3050, 10);
    add_sample(12'd3600, 10);
    add_sample(12'd3650, 20);
    add_sample(12'd3580, 30);
    add_sample(12'd3620, 10);
    add_sample(12'd0, 10);
    add_sample(12'd0, 90);
    add_sample(12'd4095, 10);
    add_sample(12'd4095, 90);
    configure(16'd0, 16'd0, 16'd0);
    add_sample(12'd4095, 0);
    add_sample(12'd4094, 0);
    add_sample(12'd4094, 0);
    add_sample(12'd4093, 1);
    add_sample(12'd4094, 1);
    add_sample(12'd4093, 1);
    add_sample(12'd4092, 1);
    settle();
    write_reg(REG_SPARE, 16'hFFFF);
    @(negedge clk) cfg_wen <= 1'b0;
    add_sample(12'd4092, 1);

    configure(16'd100, 16'd50, 16'd5000);
    @(posedge clk) rx_hold = 2500;
    add_random(300);
    configure(16'hFFFF, 16'd0, 16'd0);
    add_random(100);

    settle();
    set_pace(73, 7);
    configure(16'd0, 16'hFFFF, 16'hFFFF);
    add_random(250);
    configure({4'($urandom), 12'($urandom_range(600, 1))},
              16'($urandom_range(300, 0)), 16'($urandom_range(3000, 0)));
    add_random(300);

    settle();
    set_pace(0, 0);
    configure(16'd300, 16'd20, 16'd1000);
    add_random(300);
    configure(16'd200, 16'd1, 16'hFFFF);
    fill_candidate();
    configure(16'd50, 16'd0, 16'd200);
    add_random(100);
    settle();

    $display("Checked %0d reports from %0d samples: %0d level changes, %0d heartbeats.",
             n_reports, n_samples, n_changes, n_beats);
    $display("Swept %0d register settings, a long output stall and a long candidate run.",
             n_settings);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #30_000_000;
    $display("Timeout with %0d reports still pending", due_reports.size());
    $display("Verification failed");
    $finish;
  end

endmodule
